[hw/rtl/dtdq_pkg.sv]
// ----------------------------------------------------------------------------
// dtdq_pkg
// Shared types and constants for the deduplicating task dispatch queue.
// ----------------------------------------------------------------------------
package dtdq_pkg;

    localparam int PID_SLOTS  = 4096;
    localparam int PID_W      = $clog2(PID_SLOTS);
    localparam int CNT_W      = PID_W + 1;
    localparam int BATCH_W    = 7;
    localparam int MAX_BATCH  = 64;
    localparam int BATCH_RST  = 8;
    localparam int CLASS_LOW  = 24;
    localparam int CLASS_HIGH = 35;
    localparam int TID_W      = 22;
    localparam int ARG_W      = 12;

    localparam logic REQ_ENQ  = 1'b0;
    localparam logic REQ_DISP = 1'b1;

    typedef enum logic [2:0] {
        KIND_ENQ   = 3'd0,
        KIND_DUP   = 3'd1,
        KIND_RANGE = 3'd2,
        KIND_DISP  = 3'd3,
        KIND_NONE  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ENQ,
        S_POP
    } t_state;

    typedef struct packed {
        logic             req_type;
        logic [TID_W-1:0] task_id;
        logic             arg_valid;
        logic [ARG_W-1:0] work_arg;
    } t_req;

    typedef struct packed {
        t_kind            kind;
        logic [TID_W-1:0] out_task_id;
        logic             slice_class;
        logic [CNT_W-1:0] queued_count;
        logic             last;
    } t_res;

    typedef struct packed {
        logic [PID_W-1:0] id;
        logic             cls;
    } t_entry;

endpackage

[hw/rtl/dtdq_ram.sv]
// ----------------------------------------------------------------------------
// dtdq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dtdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/dedup_task_dispatch_queue.sv]
// ----------------------------------------------------------------------------
// dedup_task_dispatch_queue
// Task FIFO with a per-id pending bitmap; enqueue dedups, dispatch pops a batch.
// ----------------------------------------------------------------------------
//  channel   signals                               direction
//  request   start, busy, i_req                    in (start/busy)
//  result    o_res_valid, o_res                    out, strobe only
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data  in (valid/ready)
//
//  After reset a clearing pass wipes the pending map, one entry a cycle,
//  with busy high. Enqueue: busy for one cycle after accept, the result
//  shows in the cycle after that. Dispatch of n tasks: busy after accept
//  until the batch is out, one result a cycle, set by the one-per-cycle queue
//  memory read. Empty dispatch: result the cycle after accept, no busy.
//  Results cannot be stalled; the config port is always ready.
// ----------------------------------------------------------------------------
module dedup_task_dispatch_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  dtdq_pkg::t_req                i_req,
    output logic                          o_res_valid,
    output dtdq_pkg::t_res                o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dtdq_pkg::BATCH_W-1:0]  i_cfg_data
);

    dtdq_pkg::t_state                  r_state, n_state;
    dtdq_pkg::t_req                    r_req, n_req;
    dtdq_pkg::t_res                    r_res, n_res;
    logic                              r_res_valid, n_res_valid;
    logic [dtdq_pkg::PID_W-1:0]        r_head, n_head;
    logic [dtdq_pkg::PID_W-1:0]        r_tail, n_tail;
    logic [dtdq_pkg::CNT_W-1:0]        r_fill, n_fill;
    logic [dtdq_pkg::PID_W-1:0]        r_clr, n_clr;
    logic [dtdq_pkg::BATCH_W-1:0]      r_left, n_left;
    logic [dtdq_pkg::BATCH_W-1:0]      r_batch;

    logic                              accept;
    logic [dtdq_pkg::BATCH_W-1:0]      lim;
    logic                              cls;
    logic                              out_of_range;

    logic                              pend_we;
    logic [dtdq_pkg::PID_W-1:0]        pend_waddr;
    logic                              pend_wdata;
    logic                              pend_rdata;
    logic                              q_we;
    dtdq_pkg::t_entry                  q_wdata;
    logic [dtdq_pkg::PID_W-1:0]        q_raddr;
    dtdq_pkg::t_entry                  q_rdata;

    dtdq_ram #(
        .WIDTH (1),
        .DEPTH (dtdq_pkg::PID_SLOTS)
    ) u_pend (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (i_req.task_id[dtdq_pkg::PID_W-1:0]),
        .o_rdata (pend_rdata)
    );

    dtdq_ram #(
        .WIDTH ($bits(dtdq_pkg::t_entry)),
        .DEPTH (dtdq_pkg::PID_SLOTS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    assign busy        = (r_state != dtdq_pkg::S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign lim = (r_batch > dtdq_pkg::BATCH_W'(dtdq_pkg::MAX_BATCH))
               ? dtdq_pkg::BATCH_W'(dtdq_pkg::MAX_BATCH) : r_batch;
    assign cls = r_req.arg_valid
              && (r_req.work_arg >= dtdq_pkg::ARG_W'(dtdq_pkg::CLASS_LOW))
              && (r_req.work_arg <= dtdq_pkg::ARG_W'(dtdq_pkg::CLASS_HIGH));
    assign out_of_range = (r_req.task_id >= dtdq_pkg::TID_W'(dtdq_pkg::PID_SLOTS));
    assign q_wdata      = '{id: r_req.task_id[dtdq_pkg::PID_W-1:0], cls: cls};

    // during a pop run, prefetch the entry after the one being emitted
    assign q_raddr = (r_state == dtdq_pkg::S_POP) ? r_head + 1'b1 : r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtdq_pkg::S_CLEAR;
            r_res_valid <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_clr       <= '0;
            r_left      <= '0;
            r_batch     <= dtdq_pkg::BATCH_W'(dtdq_pkg::BATCH_RST);
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_clr       <= n_clr;
            r_left      <= n_left;
            if (i_cfg_valid && o_cfg_ready) begin
                r_batch <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_res       = r_res;
        n_res_valid = 1'b0;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_clr       = r_clr;
        n_left      = r_left;
        pend_we     = 1'b0;
        pend_waddr  = r_clr;
        pend_wdata  = 1'b0;
        q_we        = 1'b0;

        unique case (r_state)
            dtdq_pkg::S_CLEAR: begin
                pend_we = 1'b1;
                n_clr   = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = dtdq_pkg::S_IDLE;
                end
            end
            dtdq_pkg::S_IDLE: begin
                if (accept) begin
                    n_req = i_req;
                    if (i_req.req_type == dtdq_pkg::REQ_ENQ) begin
                        n_state = dtdq_pkg::S_ENQ;
                    end else if (lim == '0 || r_fill == '0) begin
                        n_res_valid = 1'b1;
                        n_res       = '{kind: dtdq_pkg::KIND_NONE, out_task_id: '0,
                                        slice_class: 1'b0, queued_count: r_fill,
                                        last: 1'b1};
                    end else begin
                        n_left  = lim;
                        n_state = dtdq_pkg::S_POP;
                    end
                end
            end
            dtdq_pkg::S_ENQ: begin
                n_res_valid = 1'b1;
                n_state     = dtdq_pkg::S_IDLE;
                n_res       = '{kind: dtdq_pkg::KIND_RANGE, out_task_id: r_req.task_id,
                                slice_class: 1'b0, queued_count: r_fill, last: 1'b1};
                if (!out_of_range) begin
                    if (pend_rdata) begin
                        n_res.kind = dtdq_pkg::KIND_DUP;
                    end else begin
                        pend_we           = 1'b1;
                        pend_waddr        = r_req.task_id[dtdq_pkg::PID_W-1:0];
                        pend_wdata        = 1'b1;
                        q_we              = 1'b1;
                        n_tail            = r_tail + 1'b1;
                        n_fill            = r_fill + 1'b1;
                        n_res.kind        = dtdq_pkg::KIND_ENQ;
                        n_res.slice_class = cls;
                        n_res.queued_count = r_fill + 1'b1;
                    end
                end
            end
            dtdq_pkg::S_POP: begin
                pend_we     = 1'b1;
                pend_waddr  = q_rdata.id;
                pend_wdata  = 1'b0;
                n_head      = r_head + 1'b1;
                n_fill      = r_fill - 1'b1;
                n_left      = r_left - 1'b1;
                n_res_valid = 1'b1;
                n_res       = '{kind: dtdq_pkg::KIND_DISP,
                                out_task_id: dtdq_pkg::TID_W'(q_rdata.id),
                                slice_class: q_rdata.cls,
                                queued_count: r_fill - 1'b1,
                                last: (r_left == dtdq_pkg::BATCH_W'(1))
                                   || (r_fill == dtdq_pkg::CNT_W'(1))};
                if (n_res.last) begin
                    n_state = dtdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dtdq_pkg::S_IDLE;
            end
        endcase
    end

    // no results while the pending map is being wiped
    a_no_res_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtdq_pkg::S_CLEAR) |-> !r_res_valid)
        else $error("result strobe during clearing pass");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= dtdq_pkg::CNT_W'(dtdq_pkg::PID_SLOTS))
        else $error("fill count beyond capacity");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtdq_pkg::S_POP) |-> (r_fill != '0 && r_left != '0))
        else $error("pop from empty queue or exhausted batch");

    // a batch is delivered without gaps until its last beat
    a_batch_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_res.last) |=> r_res_valid)
        else $error("gap inside a dispatch batch");

    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail - r_head) == r_fill[dtdq_pkg::PID_W-1:0])
        else $error("queue pointers disagree with fill count");

endmodule

[bench/tb_dedup_task_dispatch_queue.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dedup_task_dispatch_queue
// Self-checking bench for the dedup task dispatch queue. A shadow of the
// pending map and FIFO predicts every result beat. The stimulus is a directed
// pass, then random enqueue/dispatch traffic under several batch limits and
// sender idle mixes, with a full drain before the last random phase.
// ----------------------------------------------------------------------------
module tb_dedup_task_dispatch_queue;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYCLES  = 12;
    localparam int CYCLE_LIMIT = 100000;
    localparam int TAIL_WAIT   = 80;
    localparam int PRINT_CAP   = 40;

    // Shadow of the queue state; predicts the result beats of each request.
    class task_queue_shadow;
        bit                 pend [dtdq_pkg::PID_SLOTS];
        dtdq_pkg::t_entry   slots [dtdq_pkg::PID_SLOTS];
        int unsigned head;
        int unsigned tail;
        int unsigned fill;
        int unsigned limit;
        dtdq_pkg::t_res     due_results [$];
        int unsigned n_err;
        int unsigned n_req;
        int unsigned n_disp_req;
        int unsigned n_limits;
        int unsigned kind_seen [5];

        function new();
            head  = 0;
            tail  = 0;
            fill  = 0;
            limit = dtdq_pkg::BATCH_RST;
            n_err = 0;
            n_req = 0;
            n_disp_req = 0;
            n_limits = 0;
            foreach (pend[i]) pend[i] = 1'b0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void set_limit(logic [dtdq_pkg::BATCH_W-1:0] v);
            limit = v;
            n_limits++;
        endfunction

        function void add_due(dtdq_pkg::t_kind k, logic [dtdq_pkg::TID_W-1:0] id,
                              logic cls, logic lst);
            dtdq_pkg::t_res r;
            r.kind         = k;
            r.out_task_id  = id;
            r.slice_class  = cls;
            r.queued_count = dtdq_pkg::CNT_W'(fill);
            r.last         = lst;
            due_results.push_back(r);
            kind_seen[int'(k)]++;
        endfunction

        function void take_request(dtdq_pkg::t_req r);
            int unsigned      lim;
            int unsigned      n;
            logic             cls;
            dtdq_pkg::t_entry ent;
            dtdq_pkg::t_res   fin;
            n_req++;
            if (r.req_type == dtdq_pkg::REQ_ENQ) begin
                if (r.task_id >= dtdq_pkg::TID_W'(dtdq_pkg::PID_SLOTS)) begin
                    add_due(dtdq_pkg::KIND_RANGE, r.task_id, 1'b0, 1'b1);
                end else if (pend[r.task_id[dtdq_pkg::PID_W-1:0]]) begin
                    add_due(dtdq_pkg::KIND_DUP, r.task_id, 1'b0, 1'b1);
                end else begin
                    cls = r.arg_valid && r.work_arg >= dtdq_pkg::ARG_W'(dtdq_pkg::CLASS_LOW)
                          && r.work_arg <= dtdq_pkg::ARG_W'(dtdq_pkg::CLASS_HIGH);
                    pend[r.task_id[dtdq_pkg::PID_W-1:0]] = 1'b1;
                    ent.id  = r.task_id[dtdq_pkg::PID_W-1:0];
                    ent.cls = cls;
                    slots[tail] = ent;
                    tail = (tail + 1) % dtdq_pkg::PID_SLOTS;
                    fill++;
                    add_due(dtdq_pkg::KIND_ENQ, r.task_id, cls, 1'b1);
                end
            end else begin
                n_disp_req++;
                lim = (limit > dtdq_pkg::MAX_BATCH) ? dtdq_pkg::MAX_BATCH : limit;
                n = 0;
                while (n < lim && fill > 0) begin
                    ent  = slots[head];
                    head = (head + 1) % dtdq_pkg::PID_SLOTS;
                    fill--;
                    pend[ent.id] = 1'b0;
                    add_due(dtdq_pkg::KIND_DISP, dtdq_pkg::TID_W'(ent.id), ent.cls, 1'b0);
                    n++;
                end
                if (n == 0) begin
                    add_due(dtdq_pkg::KIND_NONE, '0, 1'b0, 1'b1);
                end else begin
                    fin = due_results.pop_back();
                    fin.last = 1'b1;
                    due_results.push_back(fin);
                end
            end
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                n_err++;
                if (n_err <= PRINT_CAP)
                    $display("%0t ns: %s mismatch, expected %0h, got %0h",
                             $time, name, want, got);
            end
        endfunction

        function void match_result(dtdq_pkg::t_res got);
            dtdq_pkg::t_res want;
            if (due_results.size() == 0) begin
                n_err++;
                if (n_err <= PRINT_CAP)
                    $display("%0t ns: unexpected result beat, expected none, got %0h",
                             $time, got);
                return;
            end
            want = due_results.pop_front();
            cmp_field("kind", 32'(want.kind), 32'(got.kind));
            cmp_field("out_task_id", 32'(want.out_task_id), 32'(got.out_task_id));
            cmp_field("slice_class", 32'(want.slice_class), 32'(got.slice_class));
            cmp_field("queued_count", 32'(want.queued_count), 32'(got.queued_count));
            cmp_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    dtdq_pkg::t_req                 i_req;
    logic                           o_res_valid;
    dtdq_pkg::t_res                 o_res;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [dtdq_pkg::BATCH_W-1:0]   i_cfg_data;

    task_queue_shadow book;
    int unsigned      gap_pct;
    int unsigned      cycle_cnt;

    dedup_task_dispatch_queue uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Results cannot be held off: every strobed beat is checked on its edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid)
            book.match_result(o_res);
    end

    // Presents one request and holds it until the beat is taken.
    task automatic send_req(input dtdq_pkg::t_req r);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        book.take_request(r);
    endtask

    task automatic send_enq(input int unsigned id, input bit vld, input int unsigned arg);
        dtdq_pkg::t_req r;
        r.req_type  = dtdq_pkg::REQ_ENQ;
        r.task_id   = dtdq_pkg::TID_W'(id);
        r.arg_valid = vld;
        r.work_arg  = dtdq_pkg::ARG_W'(arg);
        send_req(r);
    endtask

    task automatic send_disp();
        dtdq_pkg::t_req r;
        r.req_type  = dtdq_pkg::REQ_DISP;
        r.task_id   = dtdq_pkg::TID_W'($urandom());
        r.arg_valid = 1'($urandom());
        r.work_arg  = dtdq_pkg::ARG_W'($urandom());
        send_req(r);
    endtask

    task automatic wait_drained();
        while (book.due_results.size() != 0) @(posedge i_clk);
    endtask

    // Only written with nothing in flight.
    task automatic write_batch_limit(input int unsigned v);
        start <= 1'b0;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= dtdq_pkg::BATCH_W'(v);
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        book.set_limit(dtdq_pkg::BATCH_W'(v));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic dtdq_pkg::t_req random_req();
        dtdq_pkg::t_req r;
        int unsigned    pick;
        r.req_type = ($urandom_range(99) < 25) ? dtdq_pkg::REQ_DISP : dtdq_pkg::REQ_ENQ;
        pick = $urandom_range(99);
        // mostly a small id pool so duplicates are frequent
        if (pick < 65)
            r.task_id = dtdq_pkg::TID_W'($urandom_range(47));
        else if (pick < 78)
            r.task_id = dtdq_pkg::TID_W'(dtdq_pkg::PID_SLOTS - 1 - $urandom_range(15));
        else if (pick < 90)
            r.task_id = dtdq_pkg::TID_W'($urandom_range(dtdq_pkg::PID_SLOTS - 1));
        else
            r.task_id = dtdq_pkg::TID_W'($urandom());
        r.arg_valid = ($urandom_range(99) < 75);
        if ($urandom_range(1) == 0)
            r.work_arg = dtdq_pkg::ARG_W'($urandom_range(dtdq_pkg::CLASS_HIGH + 5,
                                                         dtdq_pkg::CLASS_LOW - 4));
        else
            r.work_arg = dtdq_pkg::ARG_W'($urandom());
        return r;
    endfunction

    task automatic run_random(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            send_req(random_req());
    endtask

    initial begin
        book        = new();
        cycle_cnt   = 0;
        gap_pct     = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass, reset batch limit
        send_disp();                          // empty queue
        send_enq(0, 1'b1, dtdq_pkg::CLASS_LOW);         // class bounds
        send_enq(dtdq_pkg::PID_SLOTS - 1, 1'b1, dtdq_pkg::CLASS_HIGH);
        send_enq(5, 1'b1, dtdq_pkg::CLASS_LOW - 1);
        send_enq(6, 1'b1, dtdq_pkg::CLASS_HIGH + 1);
        send_enq(7, 1'b0, 30);                // in range but not valid
        send_enq(8, 1'b1, 0);
        send_enq(9, 1'b1, 4095);
        send_enq(0, 1'b1, 30);                // duplicate
        send_enq(dtdq_pkg::PID_SLOTS, 1'b1, 30);        // first id out of range
        send_enq(22'h3FFFFF, 1'b1, 4095);
        send_enq(12'hAAA, 1'b0, 12'h555);
        send_enq(12'h555, 1'b1, 12'hAAA);
        send_disp();                          // pops 8, one left
        write_batch_limit(0);
        send_disp();                          // nothing popped despite a pending task
        write_batch_limit(1);
        send_disp();
        send_disp();

        // random traffic under several limits and idle mixes
        write_batch_limit(3);
        run_random(30);
        gap_pct = 74;
        write_batch_limit(64);
        run_random(30);
        gap_pct = 27;
        write_batch_limit(1);
        run_random(25);
        gap_pct = 0;
        write_batch_limit(127);               // saturates at the batch maximum
        run_random(25);
        gap_pct = 74;
        write_batch_limit($urandom_range(127));
        run_random(20);

        // drain with saturated batches
        gap_pct = 0;
        write_batch_limit(65);
        while (book.fill > 0)
            send_disp();

        gap_pct = 27;
        write_batch_limit(5);
        run_random(20);

        start <= 1'b0;
        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Covered %0d requests (%0d dispatch) across %0d batch limit writes,",
                 book.n_req, book.n_disp_req, book.n_limits);
        $display("  beats: %0d enq, %0d dup, %0d range, %0d popped, %0d empty; %0d errors",
                 book.kind_seen[0], book.kind_seen[1], book.kind_seen[2],
                 book.kind_seen[3], book.kind_seen[4], book.n_err);
        if (book.n_err == 0 && book.due_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
